// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away in synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define TSDV_ASSERT(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`define TSDV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define TSDV_ASSERT(lbl, clk, rst_n, expr)

`define TSDV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/tsdv_pkg.sv =====
// ----------------------------------------------------------------------------
// tsdv_pkg
// shared constants, codes, saturating arithmetic and weight table contents
// ----------------------------------------------------------------------------
`default_nettype none

package tsdv_pkg;

  localparam int MAX_MARKERS  = 4096;
  localparam int CNT_W        = $clog2(MAX_MARKERS + 1);
  localparam int ADDR_W       = $clog2(MAX_MARKERS);
  localparam int WT_ENTRIES   = 1024;
  localparam int WT_AW        = $clog2(WT_ENTRIES);
  localparam int POS_W        = 31;
  localparam int RIDX_W       = 12;
  localparam int CFG_IDX_W    = 3;
  localparam int CMP_W        = (RIDX_W > CNT_W) ? RIDX_W : CNT_W;
  localparam int SURV_W       = 6;

  localparam logic signed [31:0] MINF = 32'sh8000_0000;
  localparam logic signed [31:0] MAXP = 32'sh7fff_ffff;
  localparam logic signed [31:0] MINP = 32'sh8000_0001;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] LN2_Q30 = 64'd744261118;
  localparam logic [63:0] Q29_HALF = 64'd1 << 29;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [1:0] GS_REF = 2'd0;
  localparam logic [1:0] GS_HET = 2'd1;
  localparam logic [1:0] GS_ALT = 2'd2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_POS  = 2'd1,
    ST_CAP  = 2'd2,
    ST_READ = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_REF   = 3'd0,
    CFG_INIT_HET   = 3'd1,
    CFG_INIT_ALT   = 3'd2,
    CFG_SCALE      = 3'd3,
    CFG_HOM_SINGLE = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    FS_IDLE,
    FS_MUL,
    FS_IDX,
    FS_LT,
    FS_ACS,
    FS_EMIT,
    FS_TB0,
    FS_TBL,
    FS_RD,
    FS_RES
  } fsm_e;

  typedef logic [63:0] lw_rom_t [WT_ENTRIES];

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (a == MINF || b == MINF) return MINF;
    if (s > 33'sd2147483647) return MAXP;
    if (s < -33'sd2147483647) return MINP;
    return s[31:0];
  endfunction

  function automatic logic [63:0] exp_neg_q30(input logic [63:0] x);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] prod;
    logic [63:0] r;
    longint      s;
    y    = x >> 8;
    term = Q30_ONE;
    s    = longint'(Q30_ONE);
    for (int n = 1; n <= 6; n++) begin
      prod = (term * y) >> 30;
      case (n)
        1: term = prod;
        2: term = prod / 64'd2;
        3: term = prod / 64'd3;
        4: term = prod / 64'd4;
        5: term = prod / 64'd5;
        default: term = prod / 64'd6;
      endcase
      if ((n % 2) == 1) s = s - longint'(term);
      else s = s + longint'(term);
    end
    r = (s > 0) ? 64'(s) : 64'd0;
    for (int k = 0; k < 8; k++) r = (r * r + Q29_HALF) >> 30;
    return r;
  endfunction

  function automatic logic [31:0] ln_q30(input logic [63:0] v);
    logic [63:0] vv;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] mag;
    longint      sh;
    longint      lg;
    if (v == 64'd0) return MINF;
    vv   = (v > Q30_ONE) ? Q30_ONE : v;
    sh   = 0;
    frac = 64'd0;
    for (int i = 0; i < 64; i++) begin
      if (vv < Q30_ONE) begin
        vv = vv << 1;
        sh = sh + 1;
      end
    end
    m = vv;
    for (int i = 0; i < 16; i++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m    = m >> 1;
        frac = frac | 64'd1;
      end
    end
    lg = longint'(frac) - sh * 65536;
    if (lg >= 0) return 32'd0;
    mag = 64'(-lg);
    return 32'(-longint'((mag * LN2_Q30 + Q29_HALF) >> 30));
  endfunction

  function automatic lw_rom_t lw_rom_init();
    lw_rom_t     t;
    logic [63:0] xm;
    logic [63:0] e;
    for (int i = 0; i < WT_ENTRIES; i++) begin
      xm   = (64'(2 * i + 1) << 32) / 64'(WT_ENTRIES);
      e    = exp_neg_q30(xm);
      t[i] = {ln_q30((Q30_ONE + e) >> 1), ln_q30((Q30_ONE - e) >> 1)};
    end
    return t;
  endfunction

  localparam lw_rom_t LW_ROM = lw_rom_init();

endpackage

`default_nettype wire

// ===== rtl/tsdv_ram.sv =====
// ----------------------------------------------------------------------------
// tsdv_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tsdv_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/tsdv_weight_rom.sv =====
// ----------------------------------------------------------------------------
// tsdv_weight_rom
// stay and recombination log weights by distance bin, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module tsdv_weight_rom
  import tsdv_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic [WT_AW-1:0] addr_i,
  output      logic [31:0]      lps_o,
  output      logic [31:0]      lpr_o
);

  logic [63:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= LW_ROM[addr_i];
  end

  assign lps_o = data_q[63:32];
  assign lpr_o = data_q[31:0];

endmodule

`default_nettype wire

// ===== rtl/three_state_distance_viterbi_core.sv =====
// ----------------------------------------------------------------------------
// three_state_distance_viterbi_core
// three-state log-space viterbi decoder with distance-aware transitions
// ----------------------------------------------------------------------------
// One word in, one word out. A read goes from acceptance through the path
// memory read to the result. A marker push runs through gap multiply, weight
// table lookup, transition weights, add-compare-select, emission add and
// metric write-back, and result. The first marker of a chromosome and a
// dropped push (decreasing position or full store) skip these steps. A marker
// flagged last adds a traceback, one survivor memory read and one path memory
// write per marker, or no path write when an earlier push was dropped. Results
// wait in an output register while the next word is already accepted. Survivor
// pointers and the decoded path each live in a 4096-entry memory.
`default_nettype none

`include "assert_macros.svh"

module three_state_distance_viterbi_core
  import tsdv_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [31:0]           cfg_data_i,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic                  action_i,
  input  wire logic [POS_W-1:0]      position_i,
  input  wire logic signed [31:0]    emit_ref_i,
  input  wire logic signed [31:0]    emit_het_i,
  input  wire logic signed [31:0]    emit_alt_i,
  input  wire logic                  last_marker_i,
  input  wire logic [RIDX_W-1:0]     read_index_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic [1:0]            decoded_state_o,
  output      logic [1:0]            status_o
);

  // configuration
  logic signed [31:0] init_q [3];
  logic [31:0]        scale_q;
  logic               hom1_q;

  // decoder state
  fsm_e               state_q, state_d;
  logic [POS_W-1:0]   prev_q;
  logic signed [31:0] pm_q [3];
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   dlen_q;
  logic               serr_q;

  // item in flight
  logic [POS_W-1:0]   pos_q;
  logic [POS_W-1:0]   gap_q;
  logic signed [31:0] em_q [3];
  logic               last_q;
  logic               rd_ok_q;
  logic [62:0]        x_q;
  logic signed [31:0] lps_q, lpr_q, lhh_q;
  logic signed [31:0] best_q [3];
  logic [1:0]         arg_q [3];
  logic [ADDR_W-1:0]  tb_t_q;
  logic [1:0]         cur_q;
  logic [1:0]         res_state_q;
  status_e            res_status_q;

  // output register
  logic               out_valid_q;
  logic [1:0]         out_state_q;
  status_e            out_status_q;

  // memories
  logic               surv_we, surv_re, path_we, path_re;
  logic [ADDR_W-1:0]  surv_waddr, surv_raddr, path_waddr, path_raddr;
  logic [SURV_W-1:0]  surv_wdata, surv_rdata;
  logic [1:0]         path_wdata, path_rdata;

  // weight lookup
  localparam int PROD_W = 35 + WT_AW + 1;
  logic [PROD_W-1:0]  wt_prod;
  logic [WT_AW:0]     idx_raw;
  logic [WT_AW-1:0]   rom_addr;
  logic [31:0]        rom_lps, rom_lpr;
  logic signed [31:0] lps_d, lpr_d;

  // datapath helpers
  logic               acc, is_read, err_pos, err_cap, is_first, out_free;
  logic [CNT_W-1:0]   cnt_m1;
  logic [ADDR_W-1:0]  tb_m1;
  logic signed [31:0] lt [3][3];
  logic signed [31:0] acs_best [3];
  logic [1:0]         acs_arg [3];
  logic signed [31:0] pick_best;
  logic [1:0]         pick_arg;
  logic [1:0]         tb_next;
  logic [62:0]        x_d;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != FS_IDLE);
  assign acc         = in_valid_i && !in_stall_o;
  assign is_read     = (action_i == ACT_READ);
  assign is_first    = (count_q == '0);
  assign err_pos     = !is_first && (position_i < prev_q);
  assign err_cap     = (count_q >= CNT_W'(MAX_MARKERS));
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cnt_m1      = count_q - CNT_W'(1);
  assign tb_m1       = tb_t_q - ADDR_W'(1);
  assign x_d         = 63'(gap_q) * 63'(scale_q);

  // bin index of x
  assign wt_prod = PROD_W'(x_q[50:16]) * PROD_W'(WT_ENTRIES);
  assign idx_raw = wt_prod[PROD_W-1:35];
  always_comb begin
    if ((|x_q[62:51]) || (idx_raw >= (WT_AW + 1)'(WT_ENTRIES))) begin
      rom_addr = WT_AW'(WT_ENTRIES - 1);
    end else begin
      rom_addr = idx_raw[WT_AW-1:0];
    end
  end

  tsdv_weight_rom u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .lps_o  (rom_lps),
    .lpr_o  (rom_lpr)
  );

  always_comb begin
    if (x_q == '0) begin
      lps_d = '0;
      lpr_d = MINF;
    end else begin
      lps_d = rom_lps;
      lpr_d = rom_lpr;
    end
  end

  // transition weights, from j to k
  always_comb begin
    lt[0][0] = lps_q; lt[0][1] = lpr_q; lt[0][2] = lhh_q;
    lt[1][0] = lpr_q; lt[1][1] = lps_q; lt[1][2] = lpr_q;
    lt[2][0] = lhh_q; lt[2][1] = lpr_q; lt[2][2] = lps_q;
  end

  // add-compare-select, lowest index wins ties
  always_comb begin
    logic signed [31:0] v;
    for (int k = 0; k < 3; k++) begin
      acs_best[k] = MINF;
      acs_arg[k]  = GS_REF;
      for (int j = 0; j < 3; j++) begin
        v = sat_add(pm_q[j], lt[j][k]);
        if (v > acs_best[k]) begin
          acs_best[k] = v;
          acs_arg[k]  = 2'(j);
        end
      end
    end
  end

  // final state pick
  always_comb begin
    pick_best = MINF;
    pick_arg  = GS_REF;
    for (int k = 0; k < 3; k++) begin
      if (pm_q[k] > pick_best) begin
        pick_best = pm_q[k];
        pick_arg  = 2'(k);
      end
    end
  end

  always_comb begin
    unique case (cur_q)
      GS_REF:  tb_next = surv_rdata[1:0];
      GS_HET:  tb_next = surv_rdata[3:2];
      GS_ALT:  tb_next = surv_rdata[5:4];
      default: tb_next = GS_REF;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FS_IDLE: begin
        if (acc) begin
          if (is_read) state_d = FS_RD;
          else if (err_pos || err_cap) state_d = FS_RES;
          else if (is_first) state_d = last_marker_i ? FS_TB0 : FS_RES;
          else state_d = FS_MUL;
        end
      end
      FS_MUL:  state_d = FS_IDX;
      FS_IDX:  state_d = FS_LT;
      FS_LT:   state_d = FS_ACS;
      FS_ACS:  state_d = FS_EMIT;
      FS_EMIT: state_d = last_q ? FS_TB0 : FS_RES;
      FS_TB0:  state_d = (serr_q || cnt_m1 == '0) ? FS_RES : FS_TBL;
      FS_TBL:  state_d = (tb_m1 == '0) ? FS_RES : FS_TBL;
      FS_RD:   state_d = FS_RES;
      FS_RES:  state_d = out_free ? FS_IDLE : FS_RES;
      default: state_d = FS_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    surv_we    = 1'b0;
    surv_waddr = '0;
    surv_wdata = '0;
    surv_re    = 1'b0;
    surv_raddr = tb_m1;
    path_we    = 1'b0;
    path_waddr = tb_m1;
    path_wdata = tb_next;
    path_re    = 1'b0;
    path_raddr = ADDR_W'(read_index_i);
    unique case (state_q)
      FS_IDLE: begin
        path_re = acc && is_read;
        surv_we = acc && !is_read && !err_pos && !err_cap && is_first;
      end
      FS_EMIT: begin
        surv_we    = 1'b1;
        surv_waddr = count_q[ADDR_W-1:0];
        surv_wdata = {arg_q[2], arg_q[1], arg_q[0]};
      end
      FS_TB0: begin
        surv_re    = 1'b1;
        surv_raddr = cnt_m1[ADDR_W-1:0];
        path_we    = !serr_q;
        path_waddr = cnt_m1[ADDR_W-1:0];
        path_wdata = pick_arg;
      end
      FS_TBL: begin
        surv_re = 1'b1;
        path_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tsdv_ram #(.Width(SURV_W), .Depth(MAX_MARKERS)) u_surv_ram (
    .clk_i   (clk_i),
    .we_i    (surv_we),
    .waddr_i (surv_waddr),
    .wdata_i (surv_wdata),
    .re_i    (surv_re),
    .raddr_i (surv_raddr),
    .rdata_o (surv_rdata)
  );

  tsdv_ram #(.Width(2), .Depth(MAX_MARKERS)) u_path_ram (
    .clk_i   (clk_i),
    .we_i    (path_we),
    .waddr_i (path_waddr),
    .wdata_i (path_wdata),
    .re_i    (path_re),
    .raddr_i (path_raddr),
    .rdata_o (path_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q[0] <= '0;
      init_q[1] <= '0;
      init_q[2] <= '0;
      scale_q   <= 32'd28147498;
      hom1_q    <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_INIT_REF:   init_q[0] <= cfg_data_i;
        CFG_INIT_HET:   init_q[1] <= cfg_data_i;
        CFG_INIT_ALT:   init_q[2] <= cfg_data_i;
        CFG_SCALE:      scale_q   <= cfg_data_i;
        CFG_HOM_SINGLE: hom1_q    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FS_IDLE;
      prev_q      <= '0;
      pm_q[0]     <= '0;
      pm_q[1]     <= '0;
      pm_q[2]     <= '0;
      count_q     <= '0;
      dlen_q      <= '0;
      serr_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == FS_RES && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        FS_IDLE: begin
          if (acc && !is_read) begin
            if (err_pos || err_cap) begin
              if (last_marker_i) begin
                dlen_q  <= '0;
                count_q <= '0;
                serr_q  <= 1'b0;
              end else begin
                serr_q <= 1'b1;
              end
            end else if (is_first) begin
              pm_q[0] <= sat_add(init_q[0], emit_ref_i);
              pm_q[1] <= sat_add(init_q[1], emit_het_i);
              pm_q[2] <= sat_add(init_q[2], emit_alt_i);
              prev_q  <= position_i;
              count_q <= CNT_W'(1);
            end
          end
        end
        FS_EMIT: begin
          for (int k = 0; k < 3; k++) pm_q[k] <= sat_add(best_q[k], em_q[k]);
          prev_q  <= pos_q;
          count_q <= count_q + CNT_W'(1);
        end
        FS_TB0: begin
          if (serr_q || cnt_m1 == '0) begin
            dlen_q  <= serr_q ? '0 : count_q;
            count_q <= '0;
            serr_q  <= 1'b0;
          end
        end
        FS_TBL: begin
          if (tb_m1 == '0) begin
            dlen_q  <= count_q;
            count_q <= '0;
            serr_q  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      FS_IDLE: begin
        pos_q        <= position_i;
        gap_q        <= position_i - prev_q;
        em_q[0]      <= emit_ref_i;
        em_q[1]      <= emit_het_i;
        em_q[2]      <= emit_alt_i;
        last_q       <= last_marker_i;
        rd_ok_q      <= CMP_W'(read_index_i) < CMP_W'(dlen_q);
        res_state_q  <= GS_REF;
        if (err_pos) res_status_q <= ST_POS;
        else if (err_cap) res_status_q <= ST_CAP;
        else res_status_q <= ST_OK;
      end
      FS_MUL: x_q <= x_d;
      FS_LT: begin
        lps_q <= lps_d;
        lpr_q <= lpr_d;
        lhh_q <= hom1_q ? lpr_d : sat_add(lpr_d, lpr_d);
      end
      FS_ACS: begin
        for (int k = 0; k < 3; k++) begin
          best_q[k] <= acs_best[k];
          arg_q[k]  <= acs_arg[k];
        end
      end
      FS_TB0: begin
        tb_t_q <= cnt_m1[ADDR_W-1:0];
        cur_q  <= pick_arg;
      end
      FS_TBL: begin
        tb_t_q <= tb_m1;
        cur_q  <= tb_next;
      end
      FS_RD: begin
        res_state_q  <= rd_ok_q ? path_rdata : GS_REF;
        res_status_q <= rd_ok_q ? ST_OK : ST_READ;
      end
      FS_RES: begin
        if (out_free) begin
          out_state_q  <= res_state_q;
          out_status_q <= res_status_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign decoded_state_o = out_state_q;
  assign status_o        = out_status_q;

  `TSDV_ASSERT(a_count_max, clk_i, rst_ni, count_q <= CNT_W'(MAX_MARKERS))
  `TSDV_ASSERT(a_dlen_max, clk_i, rst_ni, dlen_q <= CNT_W'(MAX_MARKERS))
  `TSDV_ASSERT_IMP(a_fail_state, clk_i, rst_ni, out_valid_o && status_o != ST_OK, decoded_state_o == GS_REF)
  `TSDV_ASSERT_IMP(a_tb_clear, clk_i, rst_ni, state_q == FS_RES && $past(state_q) == FS_TBL, count_q == '0 && !serr_q)

endmodule

`default_nettype wire

// ===== tb/genotype_path_checker.sv =====
// ----------------------------------------------------------------------------
// genotype_path_checker
// watches the config, input and output channels of the viterbi core, predicts
// every result word from its own model of the decoder and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module genotype_path_checker
  import tsdv_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  action_i,
  input  logic [POS_W-1:0]      position_i,
  input  logic signed [31:0]    emit_ref_i,
  input  logic signed [31:0]    emit_het_i,
  input  logic signed [31:0]    emit_alt_i,
  input  logic                  last_marker_i,
  input  logic [RIDX_W-1:0]     read_index_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [1:0]            decoded_state_i,
  input  logic [1:0]            status_i,
  output int                    pending_o,
  output int                    fail_count_o
);

  typedef struct packed {
    logic [1:0] gstate;
    status_e    status;
  } call_t;

  call_t pending_calls[$];

  logic signed [31:0] init_q [3];
  logic [31:0]        scale_q;
  logic               hom_single_q;

  logic [30:0]        last_pos;
  logic signed [31:0] metric [3];
  logic [5:0]         surv_mem [MAX_MARKERS];
  logic [1:0]         path_mem [MAX_MARKERS];
  int                 n_markers;
  int                 path_len;
  logic               broken;
  logic signed [31:0] stay_rom [WT_ENTRIES];
  logic signed [31:0] recomb_rom [WT_ENTRIES];

  function automatic logic signed [31:0] sum_sat(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    longint s;
    if (a == MINF || b == MINF) return MINF;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) return MAXP;
    if (s < -64'sd2147483647) return MINP;
    return s[31:0];
  endfunction

  function automatic longint unsigned decay_q30(longint unsigned x);
    longint unsigned y, term, r;
    longint          s;
    y    = x >> 8;
    term = 64'd1 << 30;
    s    = 64'sd1 << 30;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * y) >> 30) / longint'(n);
      if (n % 2 == 1) s = s - longint'(term);
      else s = s + longint'(term);
    end
    r = (s > 0) ? longint'(s) : 0;
    for (int k = 0; k < 8; k++) r = (r * r + (64'd1 << 29)) >> 30;
    return r;
  endfunction

  function automatic logic signed [31:0] log_q30(longint unsigned v);
    longint          sh, lg;
    longint unsigned m, frac, mag;
    if (v == 0) return MINF;
    if (v > (64'd1 << 30)) v = 64'd1 << 30;
    sh   = 0;
    frac = 0;
    while (v < (64'd1 << 30)) begin
      v  = v << 1;
      sh = sh + 1;
    end
    m = v;
    for (int i = 0; i < 16; i++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m    = m >> 1;
        frac = frac | 1;
      end
    end
    lg = longint'(frac) - sh * 65536;
    if (lg >= 0) return 32'sd0;
    mag = longint'(-lg);
    return 32'(-longint'((mag * 64'd744261118 + (64'd1 << 29)) >> 30));
  endfunction

  initial begin
    longint unsigned xm, e;
    for (int i = 0; i < WT_ENTRIES; i++) begin
      xm            = (longint'(2 * i + 1) << 32) / WT_ENTRIES;
      e             = decay_q30(xm);
      stay_rom[i]   = log_q30(((64'd1 << 30) + e) >> 1);
      recomb_rom[i] = log_q30(((64'd1 << 30) - e) >> 1);
    end
  end

  task automatic close_chromosome();
    logic signed [31:0] best;
    logic [1:0]         pick;
    if (broken || n_markers == 0) begin
      path_len = 0;
    end else begin
      best = MINF;
      pick = GS_REF;
      for (int k = 0; k < 3; k++)
        if (metric[k] > best) begin
          best = metric[k];
          pick = 2'(k);
        end
      path_mem[n_markers-1] = pick;
      for (int t = n_markers - 1; t > 0; t--)
        path_mem[t-1] = 2'(surv_mem[t] >> (2 * path_mem[t]));
      path_len = n_markers;
    end
    n_markers = 0;
    broken    = 1'b0;
  endtask

  task automatic decode_word(output call_t res);
    logic signed [31:0] em [3];
    logic signed [31:0] lt [3][3];
    logic signed [31:0] nm [3];
    logic signed [31:0] lps, lpr, lhh, best, v;
    longint unsigned    x, idx;
    logic [5:0]         surv;
    int                 arg;
    res.gstate = GS_REF;
    res.status = ST_OK;
    if (action_i == ACT_READ) begin
      if (int'(read_index_i) < path_len) res.gstate = path_mem[read_index_i];
      else res.status = ST_READ;
    end else begin
      em[0] = emit_ref_i;
      em[1] = emit_het_i;
      em[2] = emit_alt_i;
      if (n_markers > 0 && position_i < last_pos) begin
        res.status = ST_POS;
        broken     = 1'b1;
      end else if (n_markers >= MAX_MARKERS) begin
        res.status = ST_CAP;
        broken     = 1'b1;
      end else if (n_markers == 0) begin
        for (int k = 0; k < 3; k++) metric[k] = sum_sat(init_q[k], em[k]);
        surv_mem[0] = '0;
        last_pos    = position_i;
        n_markers   = 1;
      end else begin
        x = longint'(position_i - last_pos) * longint'(scale_q);
        if (x == 0) begin
          lps = 32'sd0;
          lpr = MINF;
        end else begin
          idx = (x >= (64'd1 << 51)) ? WT_ENTRIES - 1 : (((x >> 16) * WT_ENTRIES) >> 35);
          if (idx >= WT_ENTRIES) idx = WT_ENTRIES - 1;
          lps = stay_rom[idx];
          lpr = recomb_rom[idx];
        end
        lhh = hom_single_q ? lpr : sum_sat(lpr, lpr);
        lt[0][0] = lps; lt[0][1] = lpr; lt[0][2] = lhh;
        lt[1][0] = lpr; lt[1][1] = lps; lt[1][2] = lpr;
        lt[2][0] = lhh; lt[2][1] = lpr; lt[2][2] = lps;
        surv = '0;
        for (int k = 0; k < 3; k++) begin
          best = MINF;
          arg  = 0;
          for (int j = 0; j < 3; j++) begin
            v = sum_sat(metric[j], lt[j][k]);
            if (v > best) begin
              best = v;
              arg  = j;
            end
          end
          nm[k] = sum_sat(best, em[k]);
          surv  = surv | 6'(arg << (2 * k));
        end
        for (int k = 0; k < 3; k++) metric[k] = nm[k];
        surv_mem[n_markers] = surv;
        last_pos            = position_i;
        n_markers++;
      end
      if (last_marker_i) close_chromosome();
    end
  endtask

  task automatic report(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    init_q       = '{default: 32'sd0};
    scale_q      = 32'd28147498;
    hom_single_q = 1'b0;
    last_pos     = '0;
    metric       = '{default: 32'sd0};
    n_markers    = 0;
    path_len     = 0;
    broken       = 1'b0;
  end

  always @(posedge clk_i) begin
    call_t res, want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_INIT_REF:   init_q[0] = cfg_data_i;
          CFG_INIT_HET:   init_q[1] = cfg_data_i;
          CFG_INIT_ALT:   init_q[2] = cfg_data_i;
          CFG_SCALE:      scale_q = cfg_data_i;
          CFG_HOM_SINGLE: hom_single_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        decode_word(res);
        pending_calls.push_back(res);
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_calls.size() == 0) begin
          report("unexpected word", status_i, -1);
        end else begin
          want = pending_calls.pop_front();
          if (decoded_state_i != want.gstate)
            report("decoded_state", decoded_state_i, want.gstate);
          if (status_i != want.status) report("status", status_i, want.status);
        end
      end
    end
    pending_o = pending_calls.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// stimulus for the three-state viterbi core: directed markers and reads, then
// random chromosomes under three idle regimes
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import tsdv_pkg::*;

  localparam int STALL_LIMIT = 60000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]          cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 action_i;
  logic [POS_W-1:0]     position_i;
  logic signed [31:0]   emit_ref_i;
  logic signed [31:0]   emit_het_i;
  logic signed [31:0]   emit_alt_i;
  logic                 last_marker_i;
  logic [RIDX_W-1:0]    read_index_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [1:0]           decoded_state_o;
  logic [1:0]           status_o;

  int pending;
  int fail_count;
  int send_idle_pct;
  int recv_idle_pct;
  int words_sent;
  int quiet_cycles;
  logic [30:0] cur_pos;

  three_state_distance_viterbi_core DUT (.*);

  genotype_path_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .action_i, .position_i,
    .emit_ref_i, .emit_het_i, .emit_alt_i, .last_marker_i, .read_index_i,
    .out_valid_i(out_valid_o), .out_stall_i, .decoded_state_i(decoded_state_o),
    .status_i(status_o), .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("three_state_distance_viterbi_core test failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_word(logic act, logic [30:0] pos, logic signed [31:0] er,
                           logic signed [31:0] eh, logic signed [31:0] ea,
                           logic lst, logic [11:0] ridx);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    action_i      = act;
    position_i    = pos;
    emit_ref_i    = er;
    emit_het_i    = eh;
    emit_alt_i    = ea;
    last_marker_i = lst;
    read_index_i  = ridx;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic push(logic [30:0] pos, logic signed [31:0] er, logic signed [31:0] eh,
                      logic signed [31:0] ea, logic lst);
    send_word(ACT_PUSH, pos, er, eh, ea, lst, 12'($urandom));
  endtask

  task automatic read(logic [11:0] ridx);
    send_word(ACT_READ, 31'($urandom), $urandom, $urandom, $urandom,
              1'($urandom_range(1)), ridx);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_emit();
    case ($urandom_range(9))
      0: return MINF;
      1: return MAXP;
      2: return MINP;
      3: return 32'sd0;
      4: return $urandom;
      default: return -$signed({1'b0, 31'($urandom_range(32'h0008_0000))});
    endcase
  endfunction

  function automatic logic [31:0] rand_init();
    case ($urandom_range(5))
      0: return MINF;
      1: return MAXP;
      2: return 32'd0;
      3: return $urandom;
      default: return -$signed({1'b0, 31'($urandom_range(32'h0004_0000))});
    endcase
  endfunction

  task automatic random_config();
    drain();
    write_reg(CFG_INIT_REF, rand_init());
    write_reg(CFG_INIT_HET, rand_init());
    write_reg(CFG_INIT_ALT, rand_init());
    case ($urandom_range(4))
      0: write_reg(CFG_SCALE, 32'd1);
      1: write_reg(CFG_SCALE, 32'hffff_ffff);
      2: write_reg(CFG_SCALE, $urandom);
      default: write_reg(CFG_SCALE, $urandom_range(32'd200_000_000, 32'd1000));
    endcase
    write_reg(CFG_HOM_SINGLE, $urandom_range(1));
  endtask

  task automatic random_chromosome();
    int          n;
    logic [31:0] gap;
    n = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
    cur_pos = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(100000));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: gap = 0;
        1: gap = $urandom;
        2: gap = $urandom_range(100);
        default: gap = $urandom_range(200000);
      endcase
      if (i > 0) begin
        if ($urandom_range(29) == 0 && cur_pos > 0)
          cur_pos = cur_pos - 31'($urandom_range(cur_pos, 1));
        else if (32'(cur_pos) + gap > 32'h7fff_ffff) cur_pos = 31'h7fff_ffff;
        else cur_pos = cur_pos + 31'(gap);
      end
      push(cur_pos, rand_emit(), rand_emit(), rand_emit(), i == n - 1);
    end
    repeat ($urandom_range(n + 2, 1)) begin
      if ($urandom_range(5) == 0) read(12'($urandom));
      else read(12'($urandom_range(n + 1)));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    action_i      = ACT_PUSH;
    position_i    = '0;
    emit_ref_i    = '0;
    emit_het_i    = '0;
    emit_alt_i    = '0;
    last_marker_i = 1'b0;
    read_index_i  = '0;
    out_stall_i   = 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 56;
    words_sent    = 0;
    quiet_cycles  = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part: read before any path, extremes, zero gap, decrease
    read(12'd0);
    read(12'hfff);
    push(31'd0, MINF, MINF, MINF, 1'b0);
    push(31'd0, MAXP, MINP, 32'sd0, 1'b0);
    push(31'h7fff_ffff, MAXP, MAXP, MAXP, 1'b0);
    push(31'h7fff_ffff, -32'sd65536, 32'sd0, MINF, 1'b1);
    read(12'd0);
    read(12'd3);
    read(12'd4);
    drain();
    write_reg(CFG_INIT_REF, MINF);
    write_reg(CFG_INIT_HET, MAXP);
    write_reg(CFG_INIT_ALT, 32'h8000_0001);
    write_reg(CFG_SCALE, 32'hffff_ffff);
    write_reg(CFG_HOM_SINGLE, 32'd1);
    push(31'd1000, 32'sd0, -32'sd100000, 32'sd0, 1'b0);
    push(31'd1001, 32'sd0, MINF, -32'sd70000, 1'b0);
    push(31'd500, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    push(31'd2000, MINF, MINF, 32'sd0, 1'b1);
    read(12'd0);
    drain();
    write_reg(CFG_SCALE, 32'd1);
    write_reg(CFG_HOM_SINGLE, 32'd0);
    write_reg(CFG_INIT_REF, 32'd0);
    push(31'd10, -32'sd5, MINF, 32'sd0, 1'b0);
    push(31'd11, MINF, 32'sd0, -32'sd9, 1'b1);
    read(12'd0);
    read(12'd1);
    words_sent = 0;

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 56 : 0;
      recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 8 : 0;
      random_config();
      while (words_sent < (phase + 1) * 135) begin
        if ($urandom_range(7) == 0) random_config();
        random_chromosome();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("three_state_distance_viterbi_core test passed");
    else $display("three_state_distance_viterbi_core test failed");
    $finish;
  end

endmodule
